>>> design/assert_macros.svh
// assertion macros shared by the flagger modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`endif
`endif

>>> design/wrsf_pkg.sv
// shared types and constants of the window range spike flagger
package wrsf_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 16;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned RMULT_W    = 16;
  localparam int unsigned ACC_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [WLEN_W-1:0]  WIN_LEN_RST    = WLEN_W'(5);
  localparam logic [RMULT_W-1:0] RANGE_MULT_RST = RMULT_W'(768);
  localparam logic [ACC_W-1:0]   ACCURACY_RST   = ACC_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LEN    = 2'd0,
    REG_RANGE_MULT = 2'd1,
    REG_ACCURACY   = 2'd2
  } wrsf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_EMIT,
    ST_SHORT
  } wrsf_state_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;     // take the input word, write the window memory
    logic short_base; // stream too short: index base is the current sample
    logic scan_init;  // start a window walk
    logic rd;         // read one window entry
    logic rd_focus;   // the entry read is the focus sample
    logic load;       // load the output register
    logic ld_short;   // loaded word is a too-short word
    logic ld_last;    // loaded word is the last of its input
  } wrsf_cmd_t;

endpackage

>>> design/wrsf_if.sv
// handshake channel interfaces: sample input, flag output, register writes
interface wrsf_in_if;
  import wrsf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_stream;
  modport source (output valid, sample, end_of_stream, input ready);
  modport sink (input valid, sample, end_of_stream, output ready);
endinterface

interface wrsf_out_if;
  import wrsf_pkg::*;
  logic               valid;
  logic               ready;
  logic               pass_flag;
  logic [INDEX_W-1:0] sample_index;
  logic               too_short;
  logic               last;
  modport source (output valid, pass_flag, sample_index, too_short, last, input ready);
  modport sink (input valid, pass_flag, sample_index, too_short, last, output ready);
endinterface

interface wrsf_cfg_if;
  import wrsf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/wrsf_ctrl.sv
// sequencer: stream bookkeeping and the per-flag window walk
`include "assert_macros.svh"
module wrsf_ctrl #(
  parameter int unsigned MaxWindow = wrsf_pkg::MAX_WINDOW_DEF,
  localparam int unsigned IdxW = $clog2(MaxWindow),
  localparam int unsigned LenW = $clog2(MaxWindow + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_eos_i,
  output logic                in_ready_o,
  input  logic [LenW-1:0]     len_i,
  input  logic                out_free_i,
  output wrsf_pkg::wrsf_cmd_t cmd_o,
  output logic [IdxW-1:0]     pos_o
);
  import wrsf_pkg::*;

  wrsf_state_e state_q, state_d;
  logic [LenW-1:0] fill_q, fill_n;
  logic            primed_q;
  logic [IdxW-1:0] pos_q, to_q, j_q;
  logic [IdxW-1:0] half, m, from_pos, to_pos;
  logic            full, is_short, has_flags, last_pos, accept;

  // decode of the incoming word against the stream state
  always_comb begin
    fill_n    = (fill_q == LenW'(MaxWindow)) ? fill_q : fill_q + LenW'(1);
    half      = IdxW'(len_i >> 1);
    m         = IdxW'(len_i - LenW'(1));
    full      = (fill_n >= len_i);
    is_short  = !primed_q && !full && in_eos_i;
    has_flags = primed_q || full;
    from_pos  = primed_q ? half : '0;
    to_pos    = in_eos_i ? m : half;
    last_pos  = (pos_q == to_q);
    accept    = (state_q == ST_IDLE) && in_valid_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (is_short) begin
            state_d = ST_SHORT;
          end else if (has_flags) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (j_q == m) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_CALC;
      ST_CALC:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = last_pos ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SHORT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.short_base = is_short;
    cmd_o.scan_init  = (accept && has_flags) ||
                       ((state_q == ST_EMIT) && out_free_i && !last_pos);
    cmd_o.rd         = (state_q == ST_SCAN);
    cmd_o.rd_focus   = (j_q == pos_q);
    cmd_o.load       = ((state_q == ST_EMIT) || (state_q == ST_SHORT)) && out_free_i;
    cmd_o.ld_short   = (state_q == ST_SHORT);
    cmd_o.ld_last    = (state_q == ST_SHORT) || last_pos;
    pos_o            = (state_q == ST_SHORT) ? '0 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      primed_q <= 1'b0;
      pos_q    <= '0;
      to_q     <= '0;
      j_q      <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        fill_q   <= in_eos_i ? '0 : fill_n;
        primed_q <= in_eos_i ? 1'b0 : has_flags;
        pos_q    <= from_pos;
        to_q     <= to_pos;
        j_q      <= '0;
      end else if (state_q == ST_SCAN) begin
        j_q <= j_q + IdxW'(1);
      end else if ((state_q == ST_EMIT) && out_free_i && !last_pos) begin
        pos_q <= pos_q + IdxW'(1);
        j_q   <= '0;
      end
    end
  end

  `ASSERT_ALWAYS(a_fill_range, clk_i, rst_ni, fill_q <= LenW'(MaxWindow), "fill count past window depth")
  `ASSERT_IMPL(a_load_free, clk_i, rst_ni, cmd_o.load, out_free_i, "output loaded while occupied")
  `ASSERT_IMPL(a_walk_bound, clk_i, rst_ni, state_q == ST_SCAN, (pos_q <= to_q) && (j_q <= m), "walk beyond window")
  `ASSERT_IMPL(a_short_unprimed, clk_i, rst_ni, state_q == ST_SHORT, !primed_q && (fill_q == '0), "too-short word with stream state left")

endmodule

>>> design/wrsf_dp.sv
// datapath: config registers, window memory, min/max/sum walk, exact test, output register
`include "assert_macros.svh"
module wrsf_dp #(
  parameter int unsigned MaxWindow = wrsf_pkg::MAX_WINDOW_DEF,
  localparam int unsigned IdxW = $clog2(MaxWindow),
  localparam int unsigned LenW = $clog2(MaxWindow + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [wrsf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 eos_i,
  input  wrsf_pkg::wrsf_cmd_t                  cmd_i,
  input  logic [IdxW-1:0]                      pos_i,
  output logic [LenW-1:0]                      len_o,
  output logic                                 out_free_o,
  wrsf_cfg_if.sink                             cfg_i,
  wrsf_out_if.source                           out_o
);
  import wrsf_pkg::*;

  localparam int unsigned SumW  = SAMPLE_W + IdxW;
  localparam int unsigned DiffW = SAMPLE_W + IdxW + 2;
  localparam int unsigned RngW  = SAMPLE_W + 1;
  localparam int unsigned P1W   = RMULT_W + RngW;
  localparam int unsigned CmpW  = P1W + IdxW;

  // configuration registers
  logic [WLEN_W-1:0]  win_len_q;
  logic [RMULT_W-1:0] range_mult_q;
  logic [ACC_W-1:0]   accuracy_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= WIN_LEN_RST;
      range_mult_q <= RANGE_MULT_RST;
      accuracy_q   <= ACCURACY_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_WIN_LEN:    win_len_q    <= cfg_i.data[WLEN_W-1:0];
        REG_RANGE_MULT: range_mult_q <= cfg_i.data[RMULT_W-1:0];
        REG_ACCURACY:   accuracy_q   <= cfg_i.data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  // window length clamped to 3..MaxWindow
  logic [LenW-1:0] len;
  logic [IdxW-1:0] m;
  always_comb begin
    if (32'(win_len_q) < 32'd3) begin
      len = LenW'(3);
    end else if (32'(win_len_q) > 32'(MaxWindow)) begin
      len = LenW'(MaxWindow);
    end else begin
      len = LenW'(win_len_q);
    end
    m = IdxW'(len - LenW'(1));
  end
  assign len_o = len;

  // stream position
  logic [INDEX_W-1:0] seen_q, base_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (cmd_i.accept) begin
      seen_q <= eos_i ? '0 : seen_q + INDEX_W'(1);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      base_q <= cmd_i.short_base ? seen_q : seen_q - INDEX_W'(m);
    end
  end

  // circular window memory, unwritten entries read as zero
  logic [SAMPLE_W-1:0]  mem_q [MaxWindow];
  logic [MaxWindow-1:0] valid_q;
  logic [IdxW-1:0]      wp_q, wp_d, rp_q, rp_start;
  logic [IdxW+1:0]      start_raw;
  logic [SAMPLE_W-1:0]  rd_data_q;
  logic                 rd_en_q, rd_focus_q;

  always_comb begin
    wp_d = wp_q;
    if (cmd_i.accept) begin
      wp_d = (wp_q == IdxW'(MaxWindow - 1)) ? '0 : wp_q + IdxW'(1);
    end
    // oldest window entry sits len slots behind the write pointer
    start_raw = (IdxW+2)'(wp_d) + (IdxW+2)'(MaxWindow) - (IdxW+2)'(len);
    if (start_raw >= (IdxW+2)'(MaxWindow)) begin
      rp_start = IdxW'(start_raw - (IdxW+2)'(MaxWindow));
    end else begin
      rp_start = IdxW'(start_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      valid_q    <= '0;
      rd_en_q    <= 1'b0;
      rd_focus_q <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      rd_en_q    <= cmd_i.rd;
      rd_focus_q <= cmd_i.rd_focus;
      if (cmd_i.accept) begin
        valid_q[wp_q] <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        rp_q <= rp_start;
      end else if (cmd_i.rd) begin
        rp_q <= (rp_q == IdxW'(MaxWindow - 1)) ? '0 : rp_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[wp_q] <= sample_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= valid_q[rp_q] ? mem_q[rp_q] : '0;
    end
  end

  // min, max and sum of the non-focus entries, focus captured aside
  logic signed [SAMPLE_W-1:0] focus_q, mx_q, mn_q, v;
  logic signed [SumW-1:0]     sum_q;
  logic                       init_q;

  assign v = $signed(rd_data_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      init_q <= 1'b0;
    end else if (rd_en_q && !rd_focus_q) begin
      init_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sum_q <= '0;
    end else if (rd_en_q) begin
      if (rd_focus_q) begin
        focus_q <= v;
      end else begin
        sum_q <= sum_q + {{(SumW-SAMPLE_W){v[SAMPLE_W-1]}}, v};
        if (!init_q || (v > mx_q)) begin
          mx_q <= v;
        end
        if (!init_q || (v < mn_q)) begin
          mn_q <= v;
        end
      end
    end
  end

  // first stage of the test: |m*focus - sum| and range_mult * floored range
  logic signed [DiffW-1:0] fm, diff;
  logic [DiffW-1:0]        mag, mag_q;
  logic [RngW-1:0]         rng, rng_fl;
  logic [P1W-1:0]          p1_q;

  always_comb begin
    fm     = $signed(focus_q) * $signed({1'b0, m});
    diff   = fm - {{(DiffW-SumW){sum_q[SumW-1]}}, sum_q};
    mag    = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    rng    = RngW'({mx_q[SAMPLE_W-1], mx_q} - {mn_q[SAMPLE_W-1], mn_q});
    rng_fl = (rng < RngW'(accuracy_q)) ? RngW'(accuracy_q) : rng;
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag;
    p1_q  <= P1W'(rng_fl) * P1W'(range_mult_q);
  end

  // second stage: 256*|diff| against range_mult*R*m
  logic [CmpW-1:0] rhs, lhs;
  logic            pass;
  always_comb begin
    rhs  = CmpW'(p1_q) * CmpW'(m);
    lhs  = CmpW'({mag_q, 8'b0});
    pass = !(lhs > rhs);
  end

  // output register
  logic               out_valid_q, out_pass_q, out_ts_q, out_last_q;
  logic [INDEX_W-1:0] out_idx_q;

  assign out_free_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_pass_q <= cmd_i.ld_short ? 1'b0 : pass;
      out_ts_q   <= cmd_i.ld_short;
      out_last_q <= cmd_i.ld_last;
      out_idx_q  <= base_q + INDEX_W'(pos_i);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pass_flag    = out_pass_q;
  assign out_o.sample_index = out_idx_q;
  assign out_o.too_short    = out_ts_q;
  assign out_o.last         = out_last_q;

  `ASSERT_ALWAYS(a_wp_range, clk_i, rst_ni, wp_q <= IdxW'(MaxWindow - 1), "write pointer out of range")
  `ASSERT_ALWAYS(a_rp_range, clk_i, rst_ni, rp_q <= IdxW'(MaxWindow - 1), "read pointer out of range")
  `ASSERT_IMPL(a_minmax_order, clk_i, rst_ni, init_q, mx_q >= mn_q, "window max below min")
  `ASSERT_IMPL(a_short_word, clk_i, rst_ni, out_valid_q && out_ts_q, out_last_q && !out_pass_q, "bad too-short word")

endmodule

>>> design/window_range_spike_flagger.sv
// top level of the window range spike flagger
// Flags each sample word as good (pass_flag 1) or spike (pass_flag 0) by
// comparing its distance from the mean of the other samples in a window of
// the configured length against range_mult times their range, the range floored
// at accuracy; the comparison is exact by cross-multiplication. Flags leave in
// sample order: the word that first fills a window gives the flags of that
// window's first half plus its center, every later word gives one flag for
// the center of its window, and the end_of_stream word also flags the rest of
// its window; last marks the final flag caused by a word. A stream that ends
// before one full window gives a single too_short word. Each flag walks the
// window memory one entry a cycle through its single read port, then drains
// the read register and passes two test stages; after an input word the input
// is held until the last flag caused by that word is loaded, while after a
// word causing no flag the input stays ready. The last flag may sit in the
// output register while the next sample word is taken.
// Register writes are accepted every cycle and are meant to be made only while
// the block is idle.
module window_range_spike_flagger #(
  parameter int unsigned MaxWindow = wrsf_pkg::MAX_WINDOW_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  wrsf_in_if.sink     in_i,
  wrsf_out_if.source  out_o,
  wrsf_cfg_if.sink    cfg_i
);
  import wrsf_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxWindow);
  localparam int unsigned LenW = $clog2(MaxWindow + 1);

  // sequencer to datapath commands, datapath to sequencer status
  wrsf_cmd_t       cmd;
  logic [IdxW-1:0] pos;
  logic [LenW-1:0] len;
  logic            out_free;
  logic            in_ready;

  // input ready comes from the sequencer, idle between words
  assign in_i.ready = in_ready;

  wrsf_ctrl #(
    .MaxWindow (MaxWindow)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_eos_i   (in_i.end_of_stream),
    .in_ready_o (in_ready),
    .len_i      (len),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .pos_o      (pos)
  );

  // datapath holds config, window memory, test arithmetic and output word
  wrsf_dp #(
    .MaxWindow (MaxWindow)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (in_i.sample),
    .eos_i      (in_i.end_of_stream),
    .cmd_i      (cmd),
    .pos_i      (pos),
    .len_o      (len),
    .out_free_o (out_free),
    .cfg_i      (cfg_i),
    .out_o      (out_o)
  );

endmodule
